// ===== rtl/pts_pkg.sv =====
// Package for the priority task scheduler: request and result types, codes
// and the level search helper. No dependencies.
package pts_pkg;

  localparam int PRIORITY_LEVELS = 8;
  localparam int MAX_TASKS       = 64;
  localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
  localparam int ID_W            = $clog2(MAX_TASKS);
  localparam int TIME_W          = 48;
  localparam int SLICE_W         = 16;
  localparam int DEPTH_W         = 4;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX     = '1;
  localparam logic [SLICE_W-1:0] SLICE_DEFAULT = SLICE_W'(10);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SCHED  = 2'd1,
    MODE_LOCK   = 2'd2,
    MODE_UNLOCK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_UNBALANCED = 2'd1,
    STAT_SATURATED  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [ID_W-1:0]    task_id;
    logic [LVL_W-1:0]   task_priority;
    logic               running_still_runnable;
    logic [TIME_W-1:0]  now_msecs;
  } req_t;

  typedef struct packed {
    logic               switched;
    logic               postponed;
    logic [ID_W-1:0]    running_task;
    logic [ID_W-1:0]    previous_task;
    logic [TIME_W-1:0]  previous_run_msecs;
    logic [TIME_W-1:0]  next_switch_msecs;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic [PRIORITY_LEVELS-1:0][ID_W-1:0] head;
    logic [PRIORITY_LEVELS-1:0][ID_W-1:0] tail;
    logic [PRIORITY_LEVELS-1:0]           nonempty;
    logic [ID_W-1:0]                      running_id;
    logic [TIME_W-1:0]                    running_start;
    logic [TIME_W-1:0]                    next_switch;
    logic [DEPTH_W-1:0]                   lock_depth;
    logic                                 switch_pending;
  } sched_state_t;

  typedef struct packed {
    logic             link_we;
    logic [ID_W-1:0]  link_addr;
    logic [ID_W-1:0]  link_data;
    logic             level_we;
    logic [ID_W-1:0]  level_addr;
    logic [LVL_W-1:0] level_data;
  } mem_wr_t;

  // Returns the highest priority (lowest numbered) non-empty level.
  function automatic logic [LVL_W-1:0] first_level(input logic [PRIORITY_LEVELS-1:0] ne);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (ne[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/pts_link_mem.sv =====
// Task link and task level memories of the scheduler, one write port and one
// registered read port each. Depends on pts_pkg.
module pts_link_mem
  import pts_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic             rd_en,
  input  logic [ID_W-1:0]  link_rd_addr,
  input  logic [ID_W-1:0]  level_rd_addr,
  output logic [ID_W-1:0]  link_rd_data,
  output logic [LVL_W-1:0] level_rd_data
);

  logic [ID_W-1:0]  queue_next [MAX_TASKS];
  logic [LVL_W-1:0] task_level [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      queue_next[wr.link_addr] <= wr.link_data;
    end
    if (wr.level_we) begin
      task_level[wr.level_addr] <= wr.level_data;
    end
    if (rd_en) begin
      link_rd_data  <= queue_next[link_rd_addr];
      level_rd_data <= task_level[level_rd_addr];
    end
  end

endmodule

// ===== rtl/pts_step.sv =====
// Next-state and result logic for one scheduler request: append, dequeue,
// requeue, lock and unlock. Depends on pts_pkg.
module pts_step
  import pts_pkg::*;
(
  input  req_t             req,
  input  sched_state_t     st,
  input  logic [ID_W-1:0]  link_rd_data,
  input  logic [LVL_W-1:0] level_rd_data,
  input  logic [SLICE_W-1:0] timeslice,
  output sched_state_t     st_next,
  output rsp_t             rsp,
  output mem_wr_t          wr
);

  always_comb begin
    logic             do_sched;
    logic             app;
    logic [LVL_W-1:0] app_lv;
    logic [ID_W-1:0]  app_id;
    logic [LVL_W-1:0] lv;
    logic [ID_W-1:0]  nxt_id;

    st_next  = st;
    rsp      = '0;
    wr       = '0;
    do_sched = 1'b0;
    app      = 1'b0;
    app_lv   = req.task_priority;
    app_id   = req.task_id;
    lv       = first_level(st.nonempty);
    nxt_id   = st.head[lv];

    unique case (req.mode)
      MODE_ADD: begin
        app           = 1'b1;
        wr.level_we   = 1'b1;
        wr.level_addr = req.task_id;
        wr.level_data = req.task_priority;
      end
      MODE_SCHED: begin
        if (st.lock_depth != '0) begin
          st_next.switch_pending = 1'b1;
          rsp.postponed          = 1'b1;
        end else begin
          do_sched = 1'b1;
        end
      end
      MODE_LOCK: begin
        if (st.lock_depth == DEPTH_MAX) begin
          rsp.status = STAT_SATURATED;
        end else begin
          st_next.lock_depth = st.lock_depth + 1'b1;
        end
      end
      MODE_UNLOCK: begin
        if (st.lock_depth == '0) begin
          rsp.status = STAT_UNBALANCED;
        end else begin
          st_next.lock_depth = st.lock_depth - 1'b1;
          if (st.lock_depth == DEPTH_W'(1) && st.switch_pending) begin
            st_next.switch_pending = 1'b0;
            do_sched               = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_sched && (st.nonempty != '0)) begin
      if (st.head[lv] == st.tail[lv]) begin
        st_next.nonempty[lv] = 1'b0;
      end else begin
        st_next.head[lv] = link_rd_data;
      end
      if (req.running_still_runnable) begin
        app    = 1'b1;
        app_lv = level_rd_data;
        app_id = st.running_id;
      end
      rsp.switched           = 1'b1;
      rsp.previous_task      = st.running_id;
      rsp.previous_run_msecs = req.now_msecs - st.running_start;
      st_next.running_id     = nxt_id;
      st_next.running_start  = req.now_msecs;
      st_next.next_switch    = req.now_msecs + TIME_W'(timeslice);
    end

    if (app) begin
      if (st_next.nonempty[app_lv]) begin
        wr.link_we                = 1'b1;
        wr.link_addr              = st_next.tail[app_lv];
        wr.link_data              = app_id;
        st_next.tail[app_lv]      = app_id;
      end else begin
        st_next.head[app_lv]      = app_id;
        st_next.tail[app_lv]      = app_id;
        st_next.nonempty[app_lv]  = 1'b1;
      end
    end

    rsp.running_task      = st_next.running_id;
    rsp.next_switch_msecs = st_next.next_switch;
  end

endmodule

// ===== rtl/priority_task_scheduler_core.sv =====
// Top level of the strict priority multilevel FIFO task scheduler.
// Depends on pts_pkg, pts_link_mem and pts_step.
//
//   channel   handshake          payload
//   request   start / busy       req (req_t)
//   result    done               rsp (rsp_t)
//   config    cfg_we             cfg_wdata (time slice, ms)
//
// Each request is handled in two steps: the accept edge registers the request and
// reads the link and level memories, the next edge updates the queues and
// registers the result. busy is high in between, and no new request is taken
// while busy is high. done pulses for one cycle; it cannot be held.
// Reset clears all levels, takes task 0 as running and sets the slice to 10.
module priority_task_scheduler_core
  import pts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [SLICE_W-1:0] cfg_wdata
);

  sched_state_t       st;
  sched_state_t       st_next;
  req_t               req_q;
  rsp_t               rsp_next;
  mem_wr_t            wr;
  mem_wr_t            wr_gated;
  logic [SLICE_W-1:0] timeslice;
  logic [ID_W-1:0]    link_rd_data;
  logic [LVL_W-1:0]   level_rd_data;
  logic               accept;

  assign accept = start && !busy;

  always_comb begin
    wr_gated          = wr;
    wr_gated.link_we  = wr.link_we && busy;
    wr_gated.level_we = wr.level_we && busy;
  end

  pts_link_mem u_mem (
    .clk           (clk),
    .wr            (wr_gated),
    .rd_en         (accept),
    .link_rd_addr  (st.head[first_level(st.nonempty)]),
    .level_rd_addr (st.running_id),
    .link_rd_data  (link_rd_data),
    .level_rd_data (level_rd_data)
  );

  pts_step u_step (
    .req           (req_q),
    .st            (st),
    .link_rd_data  (link_rd_data),
    .level_rd_data (level_rd_data),
    .timeslice     (timeslice),
    .st_next       (st_next),
    .rsp           (rsp_next),
    .wr            (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      st        <= '0;
      timeslice <= SLICE_DEFAULT;
    end else begin
      if (cfg_we) begin
        timeslice <= cfg_wdata;
      end
      done <= busy;
      if (busy) begin
        busy <= 1'b0;
        st   <= st_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a request in flight.");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("Request held for more than one working cycle.");

  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(st))
    else $error("Scheduler state changed with no request in flight.");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.switched |-> (rsp.status == STAT_OK) && !rsp.postponed)
    else $error("A switch was reported together with an error or a deferral.");

  a_postpone_pending: assert property (@(posedge clk) disable iff (rst)
    done && rsp.postponed |-> st.switch_pending && (st.lock_depth != '0))
    else $error("Deferred schedule left no pending switch.");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for priority_task_scheduler_core: a directed table, then random requests under
// several time slices, each result checked against a predictor or a typed row. Needs pts_pkg.
module testbench;
  import pts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REQS  = 250;

  typedef struct {
    req_t r;
    int   reps;
    bit   typed;
    rsp_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               done;
  rsp_t               rsp;
  logic               cfg_we;
  logic [SLICE_W-1:0] cfg_wdata;

  logic [ID_W-1:0]    link_of  [MAX_TASKS];
  bit                 link_set [MAX_TASKS];
  logic [LVL_W-1:0]   level_of [MAX_TASKS];
  bit                 level_set[MAX_TASKS];
  logic [ID_W-1:0]    head     [PRIORITY_LEVELS];
  logic [ID_W-1:0]    tail     [PRIORITY_LEVELS];
  bit                 filled   [PRIORITY_LEVELS];
  logic [ID_W-1:0]    cur_task;
  logic [TIME_W-1:0]  cur_start;
  logic [TIME_W-1:0]  slice_end;
  logic [DEPTH_W-1:0] depth;
  bit                 deferred;
  logic [SLICE_W-1:0] slice;

  rsp_t               outcomes[$];
  logic [TIME_W-1:0]  clock_ms;
  int                 lock_burst;
  int                 steady;
  bit                 start_lowered;
  int                 cycles;
  int                 failures;
  int                 accepted;
  int                 checked;
  int                 n_switch;
  int                 n_defer;
  int                 n_sat;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  priority_task_scheduler_core i_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .req,
    .done,
    .rsp,
    .cfg_we,
    .cfg_wdata
  );

  function automatic void reset_model();
    for (int i = 0; i < MAX_TASKS; i++) begin
      link_set[i]  = 1'b0;
      level_set[i] = 1'b0;
      link_of[i]   = '0;
      level_of[i]  = '0;
    end
    for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
      head[lv]   = '0;
      tail[lv]   = '0;
      filled[lv] = 1'b0;
    end
    cur_task  = '0;
    cur_start = '0;
    slice_end = '0;
    depth     = '0;
    deferred  = 1'b0;
    slice     = SLICE_DEFAULT;
  endfunction

  function automatic void enqueue(logic [LVL_W-1:0] lv, logic [ID_W-1:0] id);
    if (filled[lv]) begin
      link_of[tail[lv]]  = id;
      link_set[tail[lv]] = 1'b1;
      tail[lv]           = id;
    end else begin
      head[lv]   = id;
      tail[lv]   = id;
      filled[lv] = 1'b1;
    end
  endfunction

  function automatic int top_level();
    for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
      if (filled[lv]) begin
        return lv;
      end
    end
    return -1;
  endfunction

  function automatic void switch_task(bit runnable, logic [TIME_W-1:0] now, inout rsp_t o);
    int              lv;
    logic [ID_W-1:0] nxt;
    logic [ID_W-1:0] prev;
    lv = top_level();
    if (lv < 0) begin
      return;
    end
    nxt = head[lv];
    if (head[lv] == tail[lv]) begin
      filled[lv] = 1'b0;
    end else begin
      head[lv] = link_of[nxt];
    end
    prev = cur_task;
    if (runnable) begin
      enqueue(level_of[prev], prev);
    end
    o.switched           = 1'b1;
    o.previous_task      = prev;
    o.previous_run_msecs = now - cur_start;
    cur_task             = nxt;
    cur_start            = now;
    slice_end            = now + TIME_W'(slice);
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    o = '0;
    case (r.mode)
      MODE_ADD: begin
        level_of[r.task_id]  = r.task_priority;
        level_set[r.task_id] = 1'b1;
        enqueue(r.task_priority, r.task_id);
      end
      MODE_SCHED: begin
        if (depth != 0) begin
          deferred    = 1'b1;
          o.postponed = 1'b1;
          n_defer++;
        end else begin
          switch_task(r.running_still_runnable, r.now_msecs, o);
        end
      end
      MODE_LOCK: begin
        if (depth == DEPTH_MAX) begin
          o.status = STAT_SATURATED;
          n_sat++;
        end else begin
          depth++;
        end
      end
      default: begin
        if (depth == 0) begin
          o.status = STAT_UNBALANCED;
        end else begin
          depth--;
          if (depth == 0 && deferred) begin
            deferred = 1'b0;
            switch_task(r.running_still_runnable, r.now_msecs, o);
          end
        end
      end
    endcase
    o.running_task      = cur_task;
    o.next_switch_msecs = slice_end;
    if (o.switched) begin
      n_switch++;
    end
    return o;
  endfunction

  // A dequeue must never follow a link, nor requeue a task at a level, that was never written.
  function automatic req_t legalise(req_t r);
    bit fires;
    int lv;
    fires = (r.mode == MODE_SCHED && depth == 0) ||
            (r.mode == MODE_UNLOCK && depth == 1 && deferred);
    lv = top_level();
    if (fires && lv >= 0) begin
      if (head[lv] != tail[lv] && !link_set[head[lv]]) begin
        r.mode = MODE_ADD;
      end else if (!level_set[cur_task]) begin
        r.running_still_runnable = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (lock_burst > 0) begin
      lock_burst--;
      r.mode = MODE_LOCK;
    end else if (pick == 99) begin
      lock_burst = 16;
      r.mode = MODE_LOCK;
    end else if (pick < 40) begin
      r.mode = MODE_ADD;
    end else if (pick < 70) begin
      r.mode = MODE_SCHED;
    end else if (pick < 84 && depth < 4) begin
      r.mode = MODE_LOCK;
    end else begin
      r.mode = MODE_UNLOCK;
    end
    if ($urandom_range(0, 9) < 7) begin
      r.task_id = ID_W'($urandom_range(0, 15));
    end else begin
      r.task_id = ID_W'($urandom);
    end
    r.task_priority          = LVL_W'($urandom);
    r.running_still_runnable = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      r.now_msecs = TIME_W'({$urandom, $urandom});
    end else begin
      clock_ms    = clock_ms + TIME_W'($urandom_range(0, 40));
      r.now_msecs = clock_ms;
    end
    return r;
  endfunction

  function automatic row_t plan_row(mode_t m, int id, int prio, bit run,
                                    logic [TIME_W-1:0] now, int reps);
    row_t rw;
    rw.r.mode                   = m;
    rw.r.task_id                = ID_W'(id);
    rw.r.task_priority          = LVL_W'(prio);
    rw.r.running_still_runnable = run;
    rw.r.now_msecs              = now;
    rw.reps                     = reps;
    rw.typed                    = 1'b0;
    rw.want                     = '0;
    return rw;
  endfunction

  function automatic rsp_t rsp_of(bit sw, int running, int prev, logic [TIME_W-1:0] ran,
                                  logic [TIME_W-1:0] nxt, status_t st);
    rsp_t o;
    o.switched           = sw;
    o.postponed          = 1'b0;
    o.running_task       = ID_W'(running);
    o.previous_task      = ID_W'(prev);
    o.previous_run_msecs = ran;
    o.next_switch_msecs  = nxt;
    o.status             = st;
    return o;
  endfunction

  task automatic idle_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (steady > 0) begin
      steady--;
      n = 0;
    end else if (pick < 3) begin
      steady = 40;
      n = 0;
    end else if (pick < 50) begin
      n = 0;
    end else if (pick < 92) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(8, 30);
    end
    if (n > 0) begin
      start <= 1'b0;
      start_lowered = 1'b1;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(req_t r, bit typed, rsp_t want);
    rsp_t p;
    start <= 1'b1;
    req   <= r;
    start_lowered = 1'b0;
    do @(posedge clk); while (busy);
    p = apply_request(r);
    outcomes.push_back(typed ? want : p);
    accepted++;
    idle_gap();
  endtask

  task automatic drain();
    if (!start_lowered) begin
      start <= 1'b0;
    end
    start_lowered = 1'b1;
    while (outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slice(logic [SLICE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice = v;
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  task automatic compare(rsp_t w, rsp_t g);
    check_field("switched", TIME_W'(w.switched), TIME_W'(g.switched));
    check_field("postponed", TIME_W'(w.postponed), TIME_W'(g.postponed));
    check_field("running_task", TIME_W'(w.running_task), TIME_W'(g.running_task));
    check_field("previous_task", TIME_W'(w.previous_task), TIME_W'(g.previous_task));
    check_field("previous_run_msecs", w.previous_run_msecs, g.previous_run_msecs);
    check_field("next_switch_msecs", w.next_switch_msecs, g.next_switch_msecs);
    check_field("status", TIME_W'(w.status), TIME_W'(g.status));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcomes.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        compare(outcomes.pop_front(), rsp);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t              plan[$];
    row_t              rw;
    logic [SLICE_W-1:0] slices[4];
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    cycles     = 0;
    failures   = 0;
    accepted   = 0;
    checked    = 0;
    n_switch   = 0;
    n_defer    = 0;
    n_sat      = 0;
    lock_burst = 0;
    steady     = 0;
    clock_ms   = '0;
    start_lowered = 1'b1;
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    rw = plan_row(MODE_SCHED, 0, 0, 1'b1, 48'd100, 1);
    rw.typed = 1'b1;
    rw.want  = rsp_of(1'b0, 0, 0, '0, '0, STAT_OK);
    plan.push_back(rw);
    rw = plan_row(MODE_UNLOCK, 0, 0, 1'b1, 48'd0, 1);
    rw.typed = 1'b1;
    rw.want  = rsp_of(1'b0, 0, 0, '0, '0, STAT_UNBALANCED);
    plan.push_back(rw);
    plan.push_back(plan_row(MODE_ADD, 5, 7, 1'b0, 48'd0, 1));
    plan.push_back(plan_row(MODE_ADD, 63, 0, 1'b1, 48'd0, 1));
    plan.push_back(plan_row(MODE_ADD, 63, 0, 1'b0, 48'd0, 1));
    plan.push_back(plan_row(MODE_ADD, 0, 3, 1'b0, 48'd0, 1));
    rw = plan_row(MODE_SCHED, 0, 0, 1'b1, 48'hFFFF_FFFF_FFFF, 1);
    rw.typed = 1'b1;
    rw.want  = rsp_of(1'b1, 63, 0, 48'hFFFF_FFFF_FFFF, 48'd9, STAT_OK);
    plan.push_back(rw);
    plan.push_back(plan_row(MODE_LOCK, 0, 0, 1'b0, 48'd10, 15));
    rw = plan_row(MODE_LOCK, 0, 0, 1'b0, 48'd10, 1);
    rw.typed = 1'b1;
    rw.want  = rsp_of(1'b0, 63, 0, '0, 48'd9, STAT_SATURATED);
    plan.push_back(rw);
    plan.push_back(plan_row(MODE_SCHED, 0, 0, 1'b1, 48'd20, 1));
    plan.push_back(plan_row(MODE_UNLOCK, 0, 0, 1'b0, 48'd30, 14));
    plan.push_back(plan_row(MODE_UNLOCK, 0, 0, 1'b1, 48'd5, 1));
    plan.push_back(plan_row(MODE_ADD, 42, 5, 1'b0, 48'd6, 1));
    plan.push_back(plan_row(MODE_ADD, 21, 2, 1'b1, 48'd7, 1));
    plan.push_back(plan_row(MODE_SCHED, 0, 0, 1'b0, 48'hAAAA_AAAA_AAAA, 1));
    plan.push_back(plan_row(MODE_SCHED, 63, 7, 1'b1, 48'h5555_5555_5555, 1));
    plan.push_back(plan_row(MODE_LOCK, 0, 0, 1'b0, 48'd40, 1));
    plan.push_back(plan_row(MODE_SCHED, 0, 0, 1'b1, 48'd50, 1));
    plan.push_back(plan_row(MODE_UNLOCK, 0, 0, 1'b0, 48'd60, 1));
    plan.push_back(plan_row(MODE_SCHED, 0, 0, 1'b1, 48'd0, 1));

    foreach (plan[i]) begin
      repeat (plan[i].reps) issue(legalise(plan[i].r), plan[i].typed, plan[i].want);
    end

    slices[0] = 16'd1;
    slices[1] = 16'hFFFF;
    slices[2] = 16'd0;
    slices[3] = SLICE_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      set_slice(slices[ph]);
      clock_ms = (ph == 1) ? 48'hFFFF_FFFF_F000 : TIME_W'($urandom);
      repeat (PHASE_REQS) issue(legalise(random_request()), 1'b0, '0);
    end

    drain();
    $display("tb: %0d requests accepted and %0d results checked over four time slices",
             accepted, checked);
    $display("tb: %0d task switches, %0d deferred schedules, %0d saturated locks",
             n_switch, n_defer, n_sat);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pts_pkg.sv
rtl/pts_link_mem.sv
rtl/pts_step.sv
rtl/priority_task_scheduler_core.sv
test/testbench.sv
